### rtl/core/mmcs_pkg.sv
// mmcs_pkg: types, action codes and constants of the midi mixer channel state core
// no dependencies; imported by mmcs_update, the top level and the checker
`timescale 1ns / 1ps

package mmcs_pkg;

   localparam int MMCS_NUM_PORTS = 4;
   localparam int MMCS_NUM_SLOTS = 6;
   localparam int MMCS_LITE_SLOTS = 3;
   localparam int MMCS_CHANS_PER_PORT = 16;

   // action codes
   localparam logic [2:0] ACT_NOTE   = 3'd0;
   localparam logic [2:0] ACT_CTRL   = 3'd1;
   localparam logic [2:0] ACT_DECAY  = 3'd2;
   localparam logic [2:0] ACT_ASSIGN = 3'd3;
   localparam logic [2:0] ACT_NUDGE  = 3'd4;
   localparam logic [2:0] ACT_RESET  = 3'd5;
   localparam logic [2:0] ACT_POLL   = 3'd6;

   localparam logic [7:0] CC_VOLUME   = 8'd7;
   localparam logic [7:0] CC_PAN      = 8'd10;
   localparam logic [7:0] UNASSIGNED  = 8'd128;
   localparam logic [7:0] SLOT0_RESET = 8'd91;
   localparam logic [7:0] SLOT1_RESET = 8'd93;
   localparam logic [6:0] PAN_CENTRE  = 7'd64;
   localparam logic [6:0] FADER_RESET = 7'd100;
   localparam logic [6:0] LEVEL_MAX   = 7'd127;

   localparam logic [7:0] DIRTY_FADER = 8'h01;
   localparam logic [7:0] DIRTY_PAN   = 8'h02;
   localparam logic [7:0] DIRTY_SLOT0 = 8'h04;

   typedef struct packed {
      logic [2:0]        action;
      logic [1:0]        port;
      logic [3:0]        channel;
      logic [2:0]        target;
      logic [7:0]        number;
      logic [6:0]        value;
      logic signed [7:0] delta;
   } mmcs_req_type;

   typedef struct packed {
      logic       msg_valid;
      logic [1:0] msg_port;
      logic [3:0] msg_channel;
      logic [6:0] msg_number;
      logic [6:0] msg_value;
      logic [6:0] meter_level;
      logic [6:0] fader_level;
      logic [6:0] pan_level;
      logic [7:0] update_flags;
   } mmcs_rsp_type;

   // fixed part of one channel entry; slot numbers and values follow it in memory
   typedef struct packed {
      logic [6:0] fader;
      logic [6:0] pan;
      logic [6:0] meter;
      logic [7:0] dirty;
   } mmcs_levels_type;

endpackage

### rtl/core/mmcs_store.sv
// mmcs_store: simple dual-port channel state memory, one write and one registered read port
// depends on nothing; instantiated by midi_mixer_channel_state_core
`timescale 1ns / 1ps

module mmcs_store #(
   parameter int DATA_W = 119,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/mmcs_update.sv
// mmcs_update: modify step of one channel entry for every action, plus the meter decay
// depends on mmcs_pkg; instantiated by midi_mixer_channel_state_core
`timescale 1ns / 1ps

module mmcs_update
   import mmcs_pkg::*;
#(
   parameter int NUM_SLOTS = MMCS_NUM_SLOTS
) (
   input  mmcs_req_type                   req,
   input  logic                           lite_mode,
   input  logic                           addr_ok,
   input  mmcs_levels_type                cur_lvl,
   input  logic [NUM_SLOTS-1:0][7:0]      cur_num,
   input  logic [NUM_SLOTS-1:0][6:0]      cur_val,
   output mmcs_levels_type                nxt_lvl,
   output logic [NUM_SLOTS-1:0][7:0]      nxt_num,
   output logic [NUM_SLOTS-1:0][6:0]      nxt_val,
   output mmcs_levels_type                dec_lvl,
   output mmcs_rsp_type                   rsp
);

   localparam int LITE_N = (NUM_SLOTS > MMCS_LITE_SLOTS) ? MMCS_LITE_SLOTS : NUM_SLOTS;

   function automatic logic [6:0] sat_add(input logic [6:0] v, input logic signed [7:0] d);
      logic signed [9:0] r;
      r = $signed({3'b000, v}) + $signed({{2{d[7]}}, d});
      if (r < 0) begin
         return 7'd0;
      end else if (r > $signed({3'b000, LEVEL_MAX})) begin
         return LEVEL_MAX;
      end
      return r[6:0];
   endfunction

   logic [NUM_SLOTS-1:0] active;
   logic [NUM_SLOTS-1:0] sel;
   logic                 slot_ok;
   logic [7:0]           sel_num;
   logic [6:0]           sel_val;
   logic [13:0]          prod;
   logic [6:0]           note_lvl;
   logic                 msg;
   logic [6:0]           mnum;
   logic [6:0]           mval;

   always_comb begin
      sel_num = '0;
      sel_val = '0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
         active[s] = !lite_mode || (s < LITE_N);
         sel[s]    = active[s] && (req.target == 3'(s + 1));
         if (sel[s]) begin
            sel_num = sel_num | cur_num[s];
            sel_val = sel_val | cur_val[s];
         end
      end
      slot_ok = |sel;
   end

   assign prod     = 14'(req.value) * 14'(cur_lvl.fader);
   assign note_lvl = prod[13:7];

   always_comb begin
      dec_lvl       = cur_lvl;
      dec_lvl.meter = (cur_lvl.meter > req.value) ? cur_lvl.meter - req.value : 7'd0;
   end

   always_comb begin
      nxt_lvl = cur_lvl;
      nxt_num = cur_num;
      nxt_val = cur_val;
      msg     = 1'b0;
      mnum    = '0;
      mval    = '0;
      case (req.action)
         ACT_NOTE: begin
            if (cur_lvl.meter < note_lvl) begin
               nxt_lvl.meter = note_lvl;
            end
         end
         ACT_CTRL: begin
            if (req.number == CC_VOLUME && cur_lvl.fader != req.value) begin
               nxt_lvl.fader = req.value;
               nxt_lvl.dirty = nxt_lvl.dirty | DIRTY_FADER;
            end
            if (req.number == CC_PAN && cur_lvl.pan != req.value) begin
               nxt_lvl.pan   = req.value;
               nxt_lvl.dirty = nxt_lvl.dirty | DIRTY_PAN;
            end
            if (!req.number[7]) begin
               for (int s = 0; s < NUM_SLOTS; s++) begin
                  if (active[s] && cur_num[s] == req.number && cur_val[s] != req.value) begin
                     nxt_val[s]    = req.value;
                     nxt_lvl.dirty = nxt_lvl.dirty | 8'(DIRTY_SLOT0 << s);
                  end
               end
            end
         end
         ACT_ASSIGN: begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
               if (sel[s]) begin
                  nxt_num[s] = req.number[7] ? UNASSIGNED : req.number;
               end
            end
         end
         ACT_NUDGE, ACT_RESET: begin
            if (req.target == 3'd0) begin
               nxt_lvl.pan = (req.action == ACT_NUDGE) ? sat_add(cur_lvl.pan, req.delta)
                                                       : PAN_CENTRE;
               msg  = 1'b1;
               mnum = CC_PAN[6:0];
               mval = nxt_lvl.pan;
            end else if (slot_ok && !sel_num[7]) begin
               mval = (req.action == ACT_NUDGE) ? sat_add(sel_val, req.delta) : 7'd0;
               for (int s = 0; s < NUM_SLOTS; s++) begin
                  if (sel[s]) begin
                     nxt_val[s] = mval;
                  end
               end
               msg  = 1'b1;
               mnum = sel_num[6:0];
            end
         end
         ACT_POLL: begin
            nxt_lvl.dirty = '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp = '0;
      if (addr_ok) begin
         rsp.msg_valid    = msg;
         rsp.msg_port     = msg ? req.port : 2'd0;
         rsp.msg_channel  = msg ? req.channel : 4'd0;
         rsp.msg_number   = mnum;
         rsp.msg_value    = mval;
         rsp.meter_level  = nxt_lvl.meter;
         rsp.fader_level  = nxt_lvl.fader;
         rsp.pan_level    = nxt_lvl.pan;
         rsp.update_flags = (req.action == ACT_POLL) ? cur_lvl.dirty : nxt_lvl.dirty;
      end
   end

endmodule

### rtl/core/midi_mixer_channel_state_core.sv
// midi_mixer_channel_state_core: top level, sequencer around the channel state memory
// depends on mmcs_pkg, mmcs_store and mmcs_update
//
//   channel  ports                         direction  beat
//   req      req_valid/req_stall/req_payload  in      one action
//   rsp      rsp_valid/rsp_stall/rsp_payload  out     one result per action
//   csr      csr_wr_en/csr_wr_data            in      lite_mode write
//
// ordinary actions: accept with the memory read, then a modify and write-back step
// once the registered read data is there
// decay passes every entry through the one write port
// after reset a clearing pass writes every entry; req_stall is high
// the result sits in an output register; the next action is accepted meanwhile and only
// its write-back waits while rsp_stall holds the previous result
`timescale 1ns / 1ps

module midi_mixer_channel_state_core
   import mmcs_pkg::*;
#(
   parameter int NUM_PORTS = MMCS_NUM_PORTS,
   parameter int NUM_SLOTS = MMCS_NUM_SLOTS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  mmcs_req_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output mmcs_rsp_type rsp_payload,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data
);

   localparam int DEPTH   = NUM_PORTS * MMCS_CHANS_PER_PORT;
   localparam int AW      = $clog2(DEPTH);
   localparam int ENTRY_W = $bits(mmcs_levels_type) + NUM_SLOTS * 15;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MODIFY,
      ST_DECAY,
      ST_DECAY_OUT
   } state_type;

   state_type       state_ff;
   logic [AW:0]     cnt_ff;
   mmcs_req_type    req_ff;
   logic            wr_pend_ff;
   logic [AW-1:0]   wr_addr_ff;
   mmcs_levels_type snap_ff;
   logic            rsp_valid_ff;
   mmcs_rsp_type    rsp_ff;
   logic            lite_ff;

   logic               mem_wr_en;
   logic [AW-1:0]      mem_wr_addr;
   logic [ENTRY_W-1:0] mem_wr_data;
   logic               mem_rd_en;
   logic [AW-1:0]      mem_rd_addr;
   logic [ENTRY_W-1:0] mem_rd_data;

   mmcs_levels_type           cur_lvl, nxt_lvl, dec_lvl, rst_lvl;
   logic [NUM_SLOTS-1:0][7:0] cur_num, nxt_num, rst_num;
   logic [NUM_SLOTS-1:0][6:0] cur_val, nxt_val;
   mmcs_rsp_type              upd_rsp;
   mmcs_rsp_type              dec_rsp;

   logic          in_ok, cur_ok;
   logic [AW+5:0] in_idx_wide, cur_idx_wide;
   logic [AW-1:0] in_idx, cur_idx;
   logic          out_free;
   logic          rsp_load;
   logic          decay_rd;

   assign in_ok        = 32'(req_payload.port) < NUM_PORTS;
   assign cur_ok       = 32'(req_ff.port) < NUM_PORTS;
   assign in_idx_wide  = {{AW{1'b0}}, req_payload.port, req_payload.channel};
   assign cur_idx_wide = {{AW{1'b0}}, req_ff.port, req_ff.channel};
   assign in_idx       = in_ok ? in_idx_wide[AW-1:0] : '0;
   assign cur_idx      = cur_ok ? cur_idx_wide[AW-1:0] : '0;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   // a new result beat goes into the output register as soon as it is free
   assign rsp_load = out_free && (state_ff == ST_MODIFY || state_ff == ST_DECAY_OUT);
   assign decay_rd = cnt_ff < (AW + 1)'(DEPTH);

   assign {cur_lvl, cur_num, cur_val} = mem_rd_data;

   // entry contents after reset
   always_comb begin
      rst_lvl.fader = FADER_RESET;
      rst_lvl.pan   = PAN_CENTRE;
      rst_lvl.meter = '0;
      rst_lvl.dirty = '0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
         if (s == 0) begin
            rst_num[s] = SLOT0_RESET;
         end else if (s == 1) begin
            rst_num[s] = SLOT1_RESET;
         end else begin
            rst_num[s] = UNASSIGNED;
         end
      end
   end

   always_comb begin
      dec_rsp = '0;
      if (cur_ok) begin
         dec_rsp.meter_level  = snap_ff.meter;
         dec_rsp.fader_level  = snap_ff.fader;
         dec_rsp.pan_level    = snap_ff.pan;
         dec_rsp.update_flags = snap_ff.dirty;
      end
   end

   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = cur_idx;
      mem_wr_data = {nxt_lvl, nxt_num, nxt_val};
      mem_rd_en   = 1'b0;
      mem_rd_addr = in_idx;
      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = cnt_ff[AW-1:0];
            mem_wr_data = {rst_lvl, rst_num, {NUM_SLOTS * 7{1'b0}}};
         end
         ST_IDLE: begin
            mem_rd_en = req_valid;
         end
         ST_MODIFY: begin
            mem_wr_en = out_free && cur_ok;
         end
         ST_DECAY: begin
            mem_rd_en   = decay_rd;
            mem_rd_addr = cnt_ff[AW-1:0];
            mem_wr_en   = wr_pend_ff;
            mem_wr_addr = wr_addr_ff;
            mem_wr_data = {dec_lvl, cur_num, cur_val};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lite_ff      <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            lite_ff <= csr_wr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == (AW + 1)'(DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  req_ff     <= req_payload;
                  cnt_ff     <= '0;
                  wr_pend_ff <= 1'b0;
                  state_ff   <= (req_payload.action == ACT_DECAY) ? ST_DECAY : ST_MODIFY;
               end
            end
            ST_MODIFY: begin
               if (out_free) begin
                  rsp_ff   <= upd_rsp;
                  state_ff <= ST_IDLE;
               end
            end
            ST_DECAY: begin
               // read one entry ahead of the write-back
               wr_pend_ff <= decay_rd;
               wr_addr_ff <= cnt_ff[AW-1:0];
               if (decay_rd) begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
               if (wr_pend_ff && wr_addr_ff == cur_idx) begin
                  snap_ff <= dec_lvl;
               end
               if (!decay_rd && !wr_pend_ff) begin
                  state_ff <= ST_DECAY_OUT;
               end
            end
            ST_DECAY_OUT: begin
               if (out_free) begin
                  rsp_ff   <= dec_rsp;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall   = state_ff != ST_IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   mmcs_store #(
      .DATA_W (ENTRY_W),
      .DEPTH  (DEPTH),
      .ADDR_W (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   mmcs_update #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_update (
      .req       (req_ff),
      .lite_mode (lite_ff),
      .addr_ok   (cur_ok),
      .cur_lvl   (cur_lvl),
      .cur_num   (cur_num),
      .cur_val   (cur_val),
      .nxt_lvl   (nxt_lvl),
      .nxt_num   (nxt_num),
      .nxt_val   (nxt_val),
      .dec_lvl   (dec_lvl),
      .rsp       (upd_rsp)
   );

endmodule

### rtl/core/mmcs_checker.sv
// mmcs_checker: port-level assertions of the channel state core, bound to the top level
// depends on mmcs_pkg and midi_mixer_channel_state_core
`timescale 1ns / 1ps

module mmcs_checker
   import mmcs_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input mmcs_rsp_type rsp_payload
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // message fields are zero without a message
   a_msg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.msg_valid |->
         rsp_payload.msg_port == 2'd0 && rsp_payload.msg_channel == 4'd0 &&
         rsp_payload.msg_number == 7'd0 && rsp_payload.msg_value == 7'd0)
      else $error("message fields set without message");

   // one action at a time: an accepted beat raises req_stall in the cycle after it
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second action accepted during read-modify-write");

   // clearing pass starts right after reset, nothing is shown yet
   a_reset_clear: assert property (@(posedge clock)
      reset |=> req_stall && !rsp_valid)
      else $error("block not in clearing pass after reset");

endmodule

bind midi_mixer_channel_state_core mmcs_checker u_mmcs_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
